// ----- rtl/ptlm_pkg.sv -----
// Shared constants, codes and control types of the demand-paging MMU.
`timescale 1ns / 1ps
`default_nettype none
package ptlm_pkg;
  localparam int PROCESSES   = 16;
  localparam int PAGES       = 64;
  localparam int FRAMES      = 256;
  localparam int ENTRIES     = PROCESSES * PAGES;
  localparam int SLOT_W      = $clog2(PROCESSES);
  localparam int PIDX_W      = $clog2(PAGES);
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int CNT_W       = PIDX_W + 1;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 9;
  localparam int LIM_W       = 7;
  localparam int PAGE_W      = 10;
  localparam int ILL_W       = 16;
  localparam logic [STAMP_W-1:0] CLOCK_TOP = 32'hFFFF_FFFE;
  localparam logic [CFG_W-1:0]   CFG_RESET = 9'd256;

  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_LIMIT  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FAULT    = 3'd1;
  localparam logic [2:0] ST_ILLEGAL  = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_LIMIT    = 3'd4;
  localparam logic [2:0] ST_NOFRAME  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_CHECK, OP_LOOK,
    OP_FREE, OP_LRU, OP_EVICT, OP_FILL, OP_RESP
  } ptlm_op_t;

  typedef struct packed {
    ptlm_op_t op;
  } ptlm_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic illegal;
    logic hit;
    logic found;
    logic scan_done;
    logic have;
    logic out_free;
  } ptlm_sts_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } ptlm_word_t;
endpackage
`default_nettype wire

// ----- rtl/ptlm_ctrl.sv -----
// Sequencer of the MMU: walks each transaction through its datapath steps.
`timescale 1ns / 1ps
`default_nettype none
module ptlm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  input  wire [1:0]           in_kind,
  output logic                in_tready,
  input  ptlm_pkg::ptlm_sts_t sts,
  output ptlm_pkg::ptlm_cmd_t cmd
);
  import ptlm_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_FREE  = 9'b000010000,
    S_LRU   = 9'b000100000,
    S_EVICT = 9'b001000000,
    S_FILL  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_ACCEPT;
          case (in_kind)
            KIND_ACCESS: state_nxt = S_CHECK;
            KIND_FINISH: state_nxt = S_FREE;
            KIND_LIMIT:  state_nxt = S_RESP;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = sts.illegal ? S_FREE : S_LOOK;
      end
      S_LOOK: begin
        cmd.op    = OP_LOOK;
        state_nxt = (sts.hit || sts.found) ? S_RESP : S_LRU;
      end
      S_FREE: begin
        cmd.op = OP_FREE;
        if (sts.scan_done) state_nxt = S_RESP;
      end
      S_LRU: begin
        cmd.op = OP_LRU;
        if (sts.scan_done) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        cmd.op    = OP_EVICT;
        state_nxt = sts.have ? S_FILL : S_RESP;
      end
      S_FILL: begin
        cmd.op    = OP_FILL;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.op = OP_RESP;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_limit_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && in_kind == KIND_LIMIT) |=> state_r == S_RESP)
    else $error("limit transaction did not go to response");
  a_free_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE && sts.scan_done) |=> state_r == S_RESP)
    else $error("free scan did not end in response");
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");
endmodule
`default_nettype wire

// ----- rtl/ptlm_dp.sv -----
// Datapath of the MMU: page table memory, frame pool, per-slot registers, result.
`timescale 1ns / 1ps
`default_nettype none
module ptlm_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ptlm_pkg::ptlm_cmd_t          cmd,
  output ptlm_pkg::ptlm_sts_t          sts,
  input  wire                          cfg_valid,
  input  wire [ptlm_pkg::CFG_W-1:0]    cfg_data,
  input  wire [1:0]                    in_kind,
  input  wire [ptlm_pkg::SLOT_W-1:0]   in_slot,
  input  wire [ptlm_pkg::PAGE_W-1:0]   in_page,
  input  wire [ptlm_pkg::LIM_W-1:0]    in_limit,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [2:0]                   out_status,
  output logic [ptlm_pkg::FRAME_W-1:0] out_frame,
  output logic                         out_evicted,
  output logic [ptlm_pkg::PIDX_W-1:0]  out_victim,
  output logic [ptlm_pkg::ILL_W-1:0]   out_illegal
);
  import ptlm_pkg::*;

  ptlm_word_t mem [ENTRIES];
  ptlm_word_t rdata_r;

  logic [CFG_W-1:0]   fcount_r;
  logic [FRAMES-1:0]  free_r;
  logic [LIM_W-1:0]   limit_r [PROCESSES];
  logic [ILL_W-1:0]   ill_r   [PROCESSES];
  logic [STAMP_W-1:0] clock_r;
  logic [ADDR_W-1:0]  clr_r;

  logic [SLOT_W-1:0]  slot_r;
  logic [PAGE_W-1:0]  page_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               proc_r;
  logic [PIDX_W-1:0]  pidx_r;
  logic               have_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [PIDX_W-1:0]  best_idx_r;
  logic [FRAME_W-1:0] best_frame_r;

  logic [2:0]         res_status_r;
  logic [FRAME_W-1:0] res_frame_r;
  logic               res_evicted_r;
  logic [PIDX_W-1:0]  res_victim_r;

  logic [ADDR_W-1:0]  e_addr, scan_addr, raddr, waddr;
  logic               we;
  ptlm_word_t         wdata;
  logic [CFG_W-1:0]   pool;
  logic               found;
  logic [FRAME_W-1:0] free_idx;
  logic               better;

  assign e_addr    = {slot_r, page_r[PIDX_W-1:0]};
  assign scan_addr = {slot_r, cnt_r[PIDX_W-1:0]};
  assign raddr     = (cmd.op == OP_CHECK) ? e_addr : scan_addr;
  assign pool      = (fcount_r > CFG_W'(FRAMES)) ? CFG_W'(FRAMES) : fcount_r;

  // lowest free frame inside the usable pool
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (free_r[f] && (CFG_W'(f) < pool)) begin
        found    = 1'b1;
        free_idx = FRAME_W'(f);
      end
    end
  end

  assign better = rdata_r.valid && (!have_r || rdata_r.stamp < best_stamp_r);

  always_comb begin
    we    = 1'b0;
    waddr = e_addr;
    wdata = '{valid: 1'b1, frame: rdata_r.frame, stamp: clock_r};
    case (cmd.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '{valid: 1'b0, frame: '0, stamp: '1};
      end
      OP_LOOK: begin
        we = rdata_r.valid || found;
        if (!rdata_r.valid) wdata.frame = free_idx;
      end
      OP_FREE: begin
        we    = proc_r && rdata_r.valid;
        waddr = {slot_r, pidx_r};
        wdata = '{valid: 1'b0, frame: '0, stamp: '1};
      end
      OP_EVICT: begin
        we    = have_r;
        waddr = {slot_r, best_idx_r};
        wdata = '{valid: 1'b0, frame: '0, stamp: '1};
      end
      OP_FILL: wdata.frame = best_frame_r;
      default: we = 1'b0;
    endcase
    if (cmd.op == OP_FILL) we = 1'b1;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r   <= CFG_RESET;
      free_r     <= '1;
      clock_r    <= '0;
      clr_r      <= '0;
      out_tvalid <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        limit_r[i] <= '0;
        ill_r[i]   <= '0;
      end
    end else begin
      if (cfg_valid) fcount_r <= cfg_data;
      if (cmd.op == OP_RESP && sts.out_free) out_tvalid <= 1'b1;
      else if (out_tready)                   out_tvalid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r + ADDR_W'(1);
        OP_ACCEPT: begin
          if (in_kind == KIND_LIMIT)
            limit_r[in_slot] <= (in_limit > LIM_W'(PAGES)) ? LIM_W'(PAGES) : in_limit;
        end
        OP_CHECK: begin
          if (clock_r < CLOCK_TOP) clock_r <= clock_r + STAMP_W'(1);
          if (sts.illegal && ill_r[slot_r] != '1)
            ill_r[slot_r] <= ill_r[slot_r] + ILL_W'(1);
        end
        OP_LOOK: begin
          if (!rdata_r.valid && found) free_r[free_idx] <= 1'b0;
        end
        OP_FREE: begin
          if (proc_r && rdata_r.valid) free_r[rdata_r.frame] <= 1'b1;
        end
        default: clr_r <= clr_r;
      endcase
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        slot_r        <= in_slot;
        page_r        <= in_page;
        cnt_r         <= '0;
        proc_r        <= 1'b0;
        res_frame_r   <= '0;
        res_evicted_r <= 1'b0;
        res_victim_r  <= '0;
        res_status_r  <= (in_kind == KIND_FINISH) ? ST_FINISHED : ST_LIMIT;
      end
      OP_CHECK: begin
        cnt_r  <= '0;
        proc_r <= 1'b0;
        if (sts.illegal) res_status_r <= ST_ILLEGAL;
      end
      OP_LOOK: begin
        cnt_r  <= '0;
        proc_r <= 1'b0;
        have_r <= 1'b0;
        if (rdata_r.valid) begin
          res_status_r <= ST_HIT;
          res_frame_r  <= rdata_r.frame;
        end else if (found) begin
          res_status_r <= ST_FAULT;
          res_frame_r  <= free_idx;
        end
      end
      OP_FREE, OP_LRU: begin
        if (!cnt_r[CNT_W-1]) cnt_r <= cnt_r + CNT_W'(1);
        proc_r <= !cnt_r[CNT_W-1];
        pidx_r <= cnt_r[PIDX_W-1:0];
        if (cmd.op == OP_LRU && proc_r && better) begin
          have_r       <= 1'b1;
          best_stamp_r <= rdata_r.stamp;
          best_idx_r   <= pidx_r;
          best_frame_r <= rdata_r.frame;
        end
      end
      OP_EVICT: begin
        if (have_r) begin
          res_status_r  <= ST_FAULT;
          res_frame_r   <= best_frame_r;
          res_evicted_r <= 1'b1;
          res_victim_r  <= best_idx_r;
        end else begin
          res_status_r <= ST_NOFRAME;
        end
      end
      OP_RESP: begin
        if (sts.out_free) begin
          out_status  <= res_status_r;
          out_frame   <= res_frame_r;
          out_evicted <= res_evicted_r;
          out_victim  <= res_victim_r;
          out_illegal <= ill_r[slot_r];
        end
      end
      default: proc_r <= proc_r;
    endcase
  end

  assign sts.clear_done = (clr_r == ADDR_W'(ENTRIES - 1));
  assign sts.illegal    = (page_r >= PAGE_W'(limit_r[slot_r])) || (page_r >= PAGE_W'(PAGES));
  assign sts.hit        = rdata_r.valid;
  assign sts.found      = found;
  assign sts.scan_done  = cnt_r[CNT_W-1];
  assign sts.have       = have_r;
  assign sts.out_free   = !out_tvalid || out_tready;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_FREE || cmd.op == OP_LRU) && cnt_r[CNT_W-1]) |-> cnt_r[CNT_W-2:0] == '0)
    else $error("scan counter overran");
  a_alloc_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOOK && !rdata_r.valid && found) |=> !free_r[$past(free_idx)])
    else $error("allocated frame still free");
  a_evict_has: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FILL) |-> have_r)
    else $error("fill without victim");
endmodule
`default_nettype wire

// ----- rtl/page_table_lru_mmu.sv -----
// Top level of the demand-paging MMU with local LRU replacement.
//
// Input stream: in_tuser carries the kind (access, finish, set limit),
// in_tdata the slot, page and limit. Each item of kind 0, 1 or 2 yields one
// result transaction: out_tuser holds the status, out_tdata the frame,
// eviction flag, victim page and the slot's illegal count. Kind 3 is taken
// and dropped. cfg_valid/cfg_data write the frame count; cfg_ready is high.
// A limit set goes straight to its response; a hit or a fault with a free
// frame passes the check and lookup steps; finish and illegal access make
// one pass over the slot's 64 entries through the single read port of the
// page table memory; fault by eviction adds a 64-entry stamp scan, then the
// victim and fill writes (skipped when nothing can be evicted). One item is
// worked on at a time; the lowest free frame comes from a combinational
// priority encoder. After reset a clearing pass sweeps all 1024 page table
// entries while in_tready stays low. If the receiver stalls, the result is
// held in the output register; the next item is still taken and worked on,
// and waits in its response step until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module page_table_lru_mmu (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [23:0] in_tdata,   // process_slot[3:0], page[13:4], page_limit[20:14]
  input  wire [1:0]  in_tuser,   // kind[1:0]
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // frame[7:0], evicted[8], victim_page[14:9],
                                 // illegal_count[30:15]
  output logic [2:0] out_tuser,  // status[2:0]
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [8:0]  cfg_data
);
  import ptlm_pkg::*;

  ptlm_cmd_t cmd;
  ptlm_sts_t sts;
  logic [FRAME_W-1:0] frame;
  logic               evicted;
  logic [PIDX_W-1:0]  victim;
  logic [ILL_W-1:0]   ill;

  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, ill, victim, evicted, frame};

  ptlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptlm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_kind     (in_tuser),
    .in_slot     (in_tdata[3:0]),
    .in_page     (in_tdata[13:4]),
    .in_limit    (in_tdata[20:14]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_tuser),
    .out_frame   (frame),
    .out_evicted (evicted),
    .out_victim  (victim),
    .out_illegal (ill)
  );
endmodule
`default_nettype wire
